>>> hdl/scsd_pkg.sv
`timescale 1ns / 1ps

package scsd_pkg;

   // Width of the stored positions; results carry them sign-extended to 32 bits.
   localparam int POS_WIDTH = 32;
   localparam int OUT_POS_WIDTH = 32;
   localparam int ARG_WIDTH = 32;
   localparam int VALUE_WIDTH = 36;

   typedef enum logic [1:0] {
      OP_DX    = 2'b00,
      OP_DY    = 2'b01,
      OP_PAUSE = 2'b10,
      OP_EXT   = 2'b11
   } op_type;

   typedef enum logic [3:0] {
      SUB_DX     = 4'd0,
      SUB_DY     = 4'd1,
      SUB_PAUSE  = 4'd2,
      SUB_PEN    = 4'd3,
      SUB_CLEAR  = 4'd4,
      SUB_KEY    = 4'd5,
      SUB_COLOUR = 4'd6
   } sub_type;

   typedef enum logic [2:0] {
      KIND_LINE   = 3'd0,
      KIND_PAUSE  = 3'd1,
      KIND_CLEAR  = 3'd2,
      KIND_KEY    = 3'd3,
      KIND_COLOUR = 3'd4
   } kind_type;

   // Extended length code that stands for four argument bytes.
   localparam logic [1:0] LEN_CODE_FOUR = 2'd3;
   localparam logic [2:0] ARG_COUNT_ONE = 3'd1;
   localparam logic [2:0] ARG_COUNT_TWO = 3'd2;
   localparam logic [2:0] ARG_COUNT_FOUR = 3'd4;

   typedef struct packed {
      logic [7:0] command_byte;
      logic       last_of_stream;
   } req_type;

   typedef struct packed {
      kind_type                        cmd_kind;
      logic signed [OUT_POS_WIDTH-1:0] x_from;
      logic signed [OUT_POS_WIDTH-1:0] y_from;
      logic signed [OUT_POS_WIDTH-1:0] x_to;
      logic signed [OUT_POS_WIDTH-1:0] y_to;
      logic signed [VALUE_WIDTH-1:0]   value;
   } rsp_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] cur_x;
      logic [POS_WIDTH-1:0] cur_y;
      logic [POS_WIDTH-1:0] mem_x;
      logic [POS_WIDTH-1:0] mem_y;
      logic                 pen_down;
      logic [2:0]           bytes_pending;
      logic [2:0]           arg_total_bytes;
      logic [3:0]           pending_subcode;
      logic [ARG_WIDTH-1:0] arg_accum;
   } state_type;

   localparam state_type STATE_RESET = '0;

endpackage

>>> hdl/sketch_command_stream_decoder_top.sv
`timescale 1ns / 1ps

// Sketch command stream decoder: takes one command byte per cycle while
// req_ready is high and gives out line, pause, clear, wait-for-key and
// colour commands. A byte is held in an input register and decoded from
// there into the result register, which is loaded only while it is empty
// or its result is being taken. The only loop is the update of the position,
// pen and argument registers. While a result waits to be taken
// one more byte is accepted into the input register, after which req_ready
// falls. A byte marked last_of_stream returns the decoder to position zero
// with the pen up; a command cut short by it is dropped.
module sketch_command_stream_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  scsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output scsd_pkg::rsp_type rsp_data
);

   logic                in_valid_ff;
   logic                in_valid_in;
   scsd_pkg::req_type   in_data_ff;
   scsd_pkg::state_type state_ff;
   scsd_pkg::state_type state_in;
   scsd_pkg::state_type state_next;
   logic                out_valid_ff;
   logic                out_valid_in;
   scsd_pkg::rsp_type   out_data_ff;
   scsd_pkg::rsp_type   out_data_in;
   scsd_pkg::rsp_type   dec_word;
   logic                dec_ok;
   logic                advance;

   scsd_decode u_decode (
      .req_word   (in_data_ff),
      .state_cur  (state_ff),
      .state_next (state_next),
      .rsp_ok     (dec_ok),
      .rsp_word   (dec_word)
   );

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      state_in = advance ? state_next : state_ff;
      out_data_in = out_data_ff;
      out_valid_in = out_valid_ff;
      if (advance && dec_ok) begin
         out_valid_in = 1'b1;
         out_data_in = dec_word;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= scsd_pkg::STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_data_ff <= req_data;
      end
      out_data_ff <= out_data_in;
   end

endmodule

>>> hdl/scsd_decode.sv
`timescale 1ns / 1ps

module scsd_decode (
   input  scsd_pkg::req_type   req_word,
   input  scsd_pkg::state_type state_cur,
   output scsd_pkg::state_type state_next,
   output logic                rsp_ok,
   output scsd_pkg::rsp_type   rsp_word
);

   logic [7:0]                         b;
   logic [scsd_pkg::ARG_WIDTH-1:0]     acc_new;
   logic [2:0]                         pend_new;
   logic [2:0]                         cnt;
   logic                               exec_go;
   logic [3:0]                         exec_sub;
   logic signed [scsd_pkg::ARG_WIDTH-1:0] exec_arg;
   logic signed [scsd_pkg::VALUE_WIDTH-1:0] arg_wide;
   logic [scsd_pkg::POS_WIDTH-1:0]     arg_pos;
   scsd_pkg::state_type                st;

   assign b = req_word.command_byte;
   assign acc_new = {state_cur.arg_accum[scsd_pkg::ARG_WIDTH-9:0], b};
   assign pend_new = state_cur.bytes_pending - 3'd1;
   assign arg_wide = scsd_pkg::VALUE_WIDTH'(exec_arg);
   assign arg_pos = exec_arg[scsd_pkg::POS_WIDTH-1:0];

   always_comb begin
      st = state_cur;
      exec_go = 1'b0;
      exec_sub = scsd_pkg::SUB_DX;
      exec_arg = '0;
      cnt = (b[5:4] == scsd_pkg::LEN_CODE_FOUR) ? scsd_pkg::ARG_COUNT_FOUR : {1'b0, b[5:4]};

      if (state_cur.bytes_pending != 3'd0) begin
         st.arg_accum = acc_new;
         st.bytes_pending = pend_new;
         if (pend_new == 3'd0) begin
            exec_go = 1'b1;
            exec_sub = state_cur.pending_subcode;
            if (state_cur.arg_total_bytes == scsd_pkg::ARG_COUNT_ONE) begin
               exec_arg = scsd_pkg::ARG_WIDTH'(signed'(acc_new[7:0]));
            end else if (state_cur.arg_total_bytes == scsd_pkg::ARG_COUNT_TWO) begin
               exec_arg = scsd_pkg::ARG_WIDTH'(signed'(acc_new[15:0]));
            end else begin
               exec_arg = signed'(acc_new);
            end
         end
      end else begin
         case (scsd_pkg::op_type'(b[7:6]))
            scsd_pkg::OP_EXT: begin
               st.pending_subcode = b[3:0];
               if (cnt == 3'd0) begin
                  exec_go = 1'b1;
                  exec_sub = b[3:0];
               end else begin
                  st.bytes_pending = cnt;
                  st.arg_total_bytes = cnt;
                  st.arg_accum = '0;
               end
            end
            scsd_pkg::OP_PAUSE: begin
               exec_go = 1'b1;
               exec_sub = scsd_pkg::SUB_PAUSE;
               exec_arg = scsd_pkg::ARG_WIDTH'({2'b00, b[5:0]});
            end
            scsd_pkg::OP_DY: begin
               exec_go = 1'b1;
               exec_sub = scsd_pkg::SUB_DY;
               exec_arg = scsd_pkg::ARG_WIDTH'(signed'(b[5:0]));
            end
            default: begin
               exec_go = 1'b1;
               exec_sub = scsd_pkg::SUB_DX;
               exec_arg = scsd_pkg::ARG_WIDTH'(signed'(b[5:0]));
            end
         endcase
      end

      rsp_ok = 1'b0;
      rsp_word = '0;
      if (exec_go) begin
         case (scsd_pkg::sub_type'(exec_sub))
            scsd_pkg::SUB_DX: begin
               st.cur_x = state_cur.cur_x + arg_pos;
            end
            scsd_pkg::SUB_DY: begin
               st.cur_y = state_cur.cur_y + arg_pos;
               if (state_cur.pen_down) begin
                  rsp_ok = 1'b1;
                  rsp_word.cmd_kind = scsd_pkg::KIND_LINE;
                  rsp_word.x_from = scsd_pkg::OUT_POS_WIDTH'(signed'(state_cur.mem_x));
                  rsp_word.y_from = scsd_pkg::OUT_POS_WIDTH'(signed'(state_cur.mem_y));
                  rsp_word.x_to = scsd_pkg::OUT_POS_WIDTH'(signed'(state_cur.cur_x));
                  rsp_word.y_to = scsd_pkg::OUT_POS_WIDTH'(signed'(st.cur_y));
               end
               st.mem_x = state_cur.cur_x;
               st.mem_y = st.cur_y;
            end
            scsd_pkg::SUB_PAUSE: begin
               rsp_ok = 1'b1;
               rsp_word.cmd_kind = scsd_pkg::KIND_PAUSE;
               // Ten times the argument as a shift-and-add.
               rsp_word.value = (arg_wide <<< 3) + (arg_wide <<< 1);
            end
            scsd_pkg::SUB_PEN: begin
               st.pen_down = ~state_cur.pen_down;
            end
            scsd_pkg::SUB_CLEAR: begin
               rsp_ok = 1'b1;
               rsp_word.cmd_kind = scsd_pkg::KIND_CLEAR;
            end
            scsd_pkg::SUB_KEY: begin
               rsp_ok = 1'b1;
               rsp_word.cmd_kind = scsd_pkg::KIND_KEY;
            end
            scsd_pkg::SUB_COLOUR: begin
               rsp_ok = 1'b1;
               rsp_word.cmd_kind = scsd_pkg::KIND_COLOUR;
               rsp_word.value = arg_wide;
            end
            default: begin
            end
         endcase
      end

      // The final word of a stream returns everything to the start-up state.
      if (req_word.last_of_stream) begin
         state_next = scsd_pkg::STATE_RESET;
      end else begin
         state_next = st;
      end
   end

endmodule
